// ----- hdl/gnt_pkg.sv -----
package gnt_pkg;

    // Width of the internal line and column counters
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Token kind codes carried by each result word
    typedef enum logic [3:0] {
        KIND_CONTENT = 4'd0,
        KIND_NONTERM = 4'd1,
        KIND_LITERAL = 4'd2,
        KIND_EPSILON = 4'd3,
        KIND_ARROW   = 4'd4,
        KIND_BAR     = 4'd5,
        KIND_AMP     = 4'd6,
        KIND_TILDE   = 4'd7,
        KIND_SEMI    = 4'd8,
        KIND_END     = 4'd9,
        KIND_ERROR   = 4'd10
    } kind_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_EMPTY    = 3'd1,
        ERR_DASH     = 3'd2,
        ERR_UNKNOWN  = 3'd3,
        ERR_UNTERM   = 3'd4
    } err_t;

    // One result word
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  content_byte;
        err_t        error_code;
        logic [15:0] token_line;
        logic [15:0] token_column;
        logic        last;
    } res_t;

    // Results produced by one accepted input word
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } push_t;

    // Queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Keyword matching progress
    localparam logic [3:0] KW_LEN  = 4'd7;
    localparam logic [3:0] KW_MISS = 4'd15;

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h65; // e
            3'd1:    ch = 8'h70; // p
            3'd2:    ch = 8'h73; // s
            3'd3:    ch = 8'h69; // i
            3'd4:    ch = 8'h6C; // l
            3'd5:    ch = 8'h6F; // o
            3'd6:    ch = 8'h6E; // n
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Saturating increment of a counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    // Clamp a counter to the 16-bit output field
    function automatic logic [15:0] clamp16(input logic [CNT_W-1:0] v);
        localparam int EW = CNT_W + 16;
        logic [EW-1:0] e;
        e = EW'(v);
        if (e > EW'(16'hFFFF))
            return 16'hFFFF;
        else
            return e[15:0];
    endfunction

    // Build a result word
    function automatic res_t make_res(input kind_t k, input logic [7:0] b, input err_t e,
                                      input logic [CNT_W-1:0] ln,
                                      input logic [CNT_W-1:0] col);
        res_t r;
        r.kind         = k;
        r.content_byte = b;
        r.error_code   = e;
        r.token_line   = clamp16(ln);
        r.token_column = clamp16(col);
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

// ----- hdl/gnt_in_if.sv -----
interface gnt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_mark;

    modport source (output valid, output in_byte, output end_mark, input ready);
    modport sink   (input valid, input in_byte, input end_mark, output ready);
endinterface

// ----- hdl/gnt_out_if.sv -----
interface gnt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [7:0]  content_byte;
    logic [2:0]  error_code;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic        last;

    modport source (output valid, output kind, output content_byte, output error_code,
                    output token_line, output token_column, output last, input ready);
    modport sink   (input valid, input kind, input content_byte, input error_code,
                    input token_line, input token_column, input last, output ready);
endinterface

// ----- hdl/grammar_notation_tokenizer.sv -----
// Grammar notation tokenizer. Takes one source byte (or an end mark) per word on
// in_stream and returns token results on out_stream: content bytes of identifiers and
// literals as they arrive, then a descriptor when the token ends, with the start line
// and column. A byte can be taken every cycle; each byte gives zero, one or two
// results, which enter a four-entry result queue in the cycle the byte is accepted
// and can be taken from the next cycle on. in_stream is ready while at least two
// queue entries are free, so the sustained rate is one byte per cycle as long as the
// results leave at one per cycle; bytes that give two results are paced by that
// single output word per cycle. After an error result the block drops every further
// byte without results until reset.
module grammar_notation_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    gnt_in_if.sink     in_stream,
    gnt_out_if.source  out_stream
);

    logic            fire;
    logic            room;
    gnt_pkg::push_t  push;
    gnt_pkg::res_t   head;

    assign in_stream.ready = room;
    assign fire            = in_stream.valid && room;

    gnt_scanner u_scanner (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .in_byte  (in_stream.in_byte),
        .end_mark (in_stream.end_mark),
        .push     (push)
    );

    gnt_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_stream.valid),
        .out_ready (out_stream.ready),
        .out_res   (head)
    );

    // Drive the result word fields
    assign out_stream.kind         = 4'(head.kind);
    assign out_stream.content_byte = head.content_byte;
    assign out_stream.error_code   = 3'(head.error_code);
    assign out_stream.token_line   = head.token_line;
    assign out_stream.token_column = head.token_column;
    assign out_stream.last         = head.last;

endmodule

// ----- hdl/gnt_scanner.sv -----
module gnt_scanner (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       in_byte,
    input  logic             end_mark,
    output gnt_pkg::push_t   push
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_LIT,
        M_LITESC,
        M_DASH,
        M_HALT
    } mode_t;

    mode_t                     mode_reg, mode_next;
    logic [gnt_pkg::CNT_W-1:0] line_reg, line_next;
    logic [gnt_pkg::CNT_W-1:0] col_reg, col_next;
    logic [gnt_pkg::CNT_W-1:0] sline_reg, sline_next;
    logic [gnt_pkg::CNT_W-1:0] scol_reg, scol_next;
    logic                      nonempty_reg, nonempty_next;
    logic [3:0]                kw_reg, kw_next;

    logic                      run_idle;
    logic                      run_lit;
    logic                      is_word;
    logic                      is_space;
    gnt_pkg::res_t             res [2];
    logic [1:0]                cnt;

    always_comb
    begin
        is_word  = (in_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
                   (in_byte == gnt_pkg::CH_USCORE);
        is_space = (in_byte == gnt_pkg::CH_SPACE) || (in_byte inside {[8'h09:8'h0D]});
    end

    // Work out the next state and the results of one word
    always_comb
    begin
        mode_next     = mode_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        sline_next    = sline_reg;
        scol_next     = scol_reg;
        nonempty_next = nonempty_reg;
        kw_next       = kw_reg;
        run_idle      = 1'b0;
        run_lit       = 1'b0;
        res[0]        = '0;
        res[1]        = '0;
        cnt           = 2'd0;

        case (mode_reg)
            M_IDLE:
            begin
                if (end_mark)
                begin
                    res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_END, 8'h00,
                                                    gnt_pkg::ERR_NONE, line_reg, col_reg);
                    cnt = cnt + 2'd1;
                end
                else
                begin
                    run_idle = 1'b1;
                end
            end
            M_IDENT:
            begin
                if (!end_mark && is_word)
                begin
                    col_next = gnt_pkg::sat_inc(col_reg);
                    if (kw_reg < gnt_pkg::KW_LEN && in_byte == gnt_pkg::kw_char(kw_reg[2:0]))
                        kw_next = kw_reg + 4'd1;
                    else
                        kw_next = gnt_pkg::KW_MISS;
                    res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_CONTENT, in_byte,
                                                    gnt_pkg::ERR_NONE, sline_reg, scol_reg);
                    cnt = cnt + 2'd1;
                end
                else
                begin
                    res[cnt[0]] = gnt_pkg::make_res(
                        (kw_reg == gnt_pkg::KW_LEN) ? gnt_pkg::KIND_EPSILON
                                                    : gnt_pkg::KIND_NONTERM,
                        8'h00, gnt_pkg::ERR_NONE, sline_reg, scol_reg);
                    cnt = cnt + 2'd1;
                    mode_next = M_IDLE;
                    if (end_mark)
                    begin
                        res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_END, 8'h00,
                                                        gnt_pkg::ERR_NONE, line_reg, col_reg);
                        cnt = cnt + 2'd1;
                    end
                    else
                    begin
                        run_idle = 1'b1;
                    end
                end
            end
            M_LIT:
            begin
                if (end_mark)
                begin
                    mode_next = M_HALT;
                    res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_ERROR, 8'h00,
                                                    gnt_pkg::ERR_UNTERM, sline_reg, scol_reg);
                    cnt = cnt + 2'd1;
                end
                else
                begin
                    run_lit = 1'b1;
                end
            end
            M_LITESC:
            begin
                if (end_mark)
                begin
                    mode_next = M_HALT;
                    res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_ERROR, 8'h00,
                                                    gnt_pkg::ERR_UNTERM, sline_reg, scol_reg);
                    cnt = cnt + 2'd1;
                end
                else if (in_byte == gnt_pkg::CH_QUOTE)
                begin
                    col_next      = gnt_pkg::sat_inc(col_reg);
                    nonempty_next = 1'b1;
                    mode_next     = M_LIT;
                    res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_CONTENT, gnt_pkg::CH_QUOTE,
                                                    gnt_pkg::ERR_NONE, sline_reg, scol_reg);
                    cnt = cnt + 2'd1;
                end
                else
                begin
                    // Lone backslash is content; the byte is then a plain literal byte
                    nonempty_next = 1'b1;
                    mode_next     = M_LIT;
                    res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_CONTENT, gnt_pkg::CH_BSLASH,
                                                    gnt_pkg::ERR_NONE, sline_reg, scol_reg);
                    cnt = cnt + 2'd1;
                    run_lit = 1'b1;
                end
            end
            M_DASH:
            begin
                if (!end_mark && in_byte == gnt_pkg::CH_GT)
                begin
                    col_next  = gnt_pkg::sat_inc(col_reg);
                    mode_next = M_IDLE;
                    res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_ARROW, 8'h00,
                                                    gnt_pkg::ERR_NONE, sline_reg, scol_reg);
                    cnt = cnt + 2'd1;
                end
                else
                begin
                    mode_next = M_HALT;
                    res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_ERROR, 8'h00,
                                                    gnt_pkg::ERR_DASH, sline_reg, scol_reg);
                    cnt = cnt + 2'd1;
                end
            end
            default:
            begin
                mode_next = M_HALT;
            end
        endcase

        // Byte between tokens
        if (run_idle)
        begin
            if (is_space)
            begin
                col_next = gnt_pkg::sat_inc(col_reg);
                if (in_byte == gnt_pkg::CH_LF || in_byte == gnt_pkg::CH_CR)
                begin
                    line_next = gnt_pkg::sat_inc(line_reg);
                    col_next  = gnt_pkg::CNT_W'(1);
                end
            end
            else
            begin
                sline_next = line_reg;
                scol_next  = col_reg;
                if (in_byte == gnt_pkg::CH_QUOTE)
                begin
                    col_next      = gnt_pkg::sat_inc(col_reg);
                    nonempty_next = 1'b0;
                    mode_next     = M_LIT;
                end
                else if (is_word)
                begin
                    col_next  = gnt_pkg::sat_inc(col_reg);
                    kw_next   = (in_byte == gnt_pkg::kw_char(3'd0)) ? 4'd1 : gnt_pkg::KW_MISS;
                    mode_next = M_IDENT;
                    res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_CONTENT, in_byte,
                                                    gnt_pkg::ERR_NONE, line_reg, col_reg);
                    cnt = cnt + 2'd1;
                end
                else if (in_byte == gnt_pkg::CH_DASH)
                begin
                    col_next  = gnt_pkg::sat_inc(col_reg);
                    mode_next = M_DASH;
                end
                else if (in_byte == gnt_pkg::CH_BAR || in_byte == gnt_pkg::CH_AMP ||
                         in_byte == gnt_pkg::CH_TILDE || in_byte == gnt_pkg::CH_SEMI)
                begin
                    col_next = gnt_pkg::sat_inc(col_reg);
                    res[cnt[0]] = gnt_pkg::make_res(
                        (in_byte == gnt_pkg::CH_BAR)   ? gnt_pkg::KIND_BAR :
                        (in_byte == gnt_pkg::CH_AMP)   ? gnt_pkg::KIND_AMP :
                        (in_byte == gnt_pkg::CH_TILDE) ? gnt_pkg::KIND_TILDE :
                                                         gnt_pkg::KIND_SEMI,
                        8'h00, gnt_pkg::ERR_NONE, line_reg, col_reg);
                    cnt = cnt + 2'd1;
                end
                else
                begin
                    mode_next = M_HALT;
                    res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_ERROR, 8'h00,
                                                    gnt_pkg::ERR_UNKNOWN, line_reg, col_reg);
                    cnt = cnt + 2'd1;
                end
            end
        end

        // Ordinary byte inside a literal
        if (run_lit)
        begin
            col_next = gnt_pkg::sat_inc(col_reg);
            if (in_byte == gnt_pkg::CH_QUOTE)
            begin
                if (!nonempty_next)
                begin
                    mode_next = M_HALT;
                    res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_ERROR, 8'h00,
                                                    gnt_pkg::ERR_EMPTY, sline_reg, scol_reg);
                end
                else
                begin
                    mode_next = M_IDLE;
                    res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_LITERAL, 8'h00,
                                                    gnt_pkg::ERR_NONE, sline_reg, scol_reg);
                end
                cnt = cnt + 2'd1;
            end
            else if (in_byte == gnt_pkg::CH_BSLASH)
            begin
                mode_next = M_LITESC;
            end
            else
            begin
                nonempty_next = 1'b1;
                res[cnt[0]] = gnt_pkg::make_res(gnt_pkg::KIND_CONTENT, in_byte,
                                                gnt_pkg::ERR_NONE, sline_reg, scol_reg);
                cnt = cnt + 2'd1;
            end
        end

        // Mark the final result of this word
        if (cnt == 2'd1)
            res[0].last = 1'b1;
        else if (cnt == 2'd2)
            res[1].last = 1'b1;
    end

    always_comb
    begin
        push.count = fire ? cnt : 2'd0;
        push.r0    = res[0];
        push.r1    = res[1];
    end

    // Hold scan state; advance on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            line_reg     <= gnt_pkg::CNT_W'(1);
            col_reg      <= gnt_pkg::CNT_W'(1);
            sline_reg    <= '0;
            scol_reg     <= '0;
            nonempty_reg <= 1'b0;
            kw_reg       <= 4'd0;
        end
        else if (fire)
        begin
            mode_reg     <= mode_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            sline_reg    <= sline_next;
            scol_reg     <= scol_next;
            nonempty_reg <= nonempty_next;
            kw_reg       <= kw_next;
        end
    end

endmodule

// ----- hdl/gnt_result_queue.sv -----
module gnt_result_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  gnt_pkg::push_t  push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output gnt_pkg::res_t   out_res
);

    localparam int CW = gnt_pkg::QPTR_W + 1;

    gnt_pkg::res_t               slot_reg [gnt_pkg::QDEPTH];
    logic [gnt_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]               count_reg, count_next;
    logic                        pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = slot_reg[rd_ptr_reg];
    // Take a word only with space for its two possible results
    assign room      = (count_reg <= CW'(gnt_pkg::QDEPTH - 2));

    always_comb
    begin
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    // Store up to two results per cycle
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            slot_reg[wr_ptr_reg] <= push.r0;
        if (push.count == 2'd2)
            slot_reg[wr_ptr_reg + gnt_pkg::QPTR_W'(1)] <= push.r1;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + gnt_pkg::QPTR_W'(push.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + gnt_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ----- tb/tb_grammar_notation_tokenizer.sv -----
module tb_grammar_notation_tokenizer;

    localparam int    CYCLE_LIMIT  = 200_000;
    localparam int    RANDOM_WORDS = 1700;
    localparam int    SETTLE       = 20;
    localparam int    LONG_HOLD    = 400;
    localparam string KEYWORD      = "epsilon";
    localparam string NAME_CHARS   =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_LIT,
        SCAN_LIT_ESC,
        SCAN_DASH,
        SCAN_HALT
    } scan_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       endm;
    } src_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic       feed_valid = 1'b0;
    logic [7:0] feed_byte  = 8'h00;
    logic       feed_end   = 1'b0;
    logic       take_ready = 1'b0;
    logic       word_taken = 1'b0;

    // Pacing controls set by the stimulus sequence
    logic sender_pace   = 1'b0;
    logic sink_pace     = 1'b0;
    int   hold_requests = 0;
    int   holds_served  = 0;
    int   long_hold_left = 0;
    int   stall_left    = 0;
    int   gap_left      = 0;

    int   cycle_count    = 0;
    int   mismatch_count = 0;
    int   words_queued   = 0;

    src_word_t       source_text[$];
    gnt_pkg::res_t   expected_tokens[$];

    // Tokenizer shadow state
    scan_t                     scan_state      = SCAN_IDLE;
    logic [gnt_pkg::CNT_W-1:0] cur_line        = gnt_pkg::CNT_W'(1);
    logic [gnt_pkg::CNT_W-1:0] cur_col         = gnt_pkg::CNT_W'(1);
    logic [gnt_pkg::CNT_W-1:0] tok_line        = '0;
    logic [gnt_pkg::CNT_W-1:0] tok_col         = '0;
    logic                      lit_has_content = 1'b0;
    logic [3:0]                kw_match        = 4'd0;
    gnt_pkg::res_t             step_out[2];
    int                        step_n;

    gnt_in_if  in_if();
    gnt_out_if out_if();

    assign in_if.valid    = feed_valid;
    assign in_if.in_byte  = feed_byte;
    assign in_if.end_mark = feed_end;
    assign out_if.ready   = take_ready;

    grammar_notation_tokenizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [gnt_pkg::CNT_W-1:0] count_up(
        input logic [gnt_pkg::CNT_W-1:0] v);
        return (v == gnt_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == gnt_pkg::CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || (c == gnt_pkg::CH_USCORE);
    endfunction

    function automatic void add_result(input gnt_pkg::kind_t k, input logic [7:0] ch,
                                       input gnt_pkg::err_t e,
                                       input logic [gnt_pkg::CNT_W-1:0] ln,
                                       input logic [gnt_pkg::CNT_W-1:0] col);
        gnt_pkg::res_t r;
        r.kind         = k;
        r.content_byte = ch;
        r.error_code   = e;
        r.token_line   = (64'(ln) > 64'hFFFF) ? 16'hFFFF : 16'(ln);
        r.token_column = (64'(col) > 64'hFFFF) ? 16'hFFFF : 16'(col);
        r.last         = 1'b0;
        step_out[step_n] = r;
        step_n++;
    endfunction

    function automatic void raise_fault(input gnt_pkg::err_t e);
        scan_state = SCAN_HALT;
        add_result(gnt_pkg::KIND_ERROR, 8'h00, e, tok_line, tok_col);
    endfunction

    // Byte seen between tokens
    function automatic void idle_char(input logic [7:0] c);
        gnt_pkg::kind_t k;
        if (is_blank(c))
        begin
            cur_col = count_up(cur_col);
            if (c == gnt_pkg::CH_LF || c == gnt_pkg::CH_CR)
            begin
                cur_line = count_up(cur_line);
                cur_col  = gnt_pkg::CNT_W'(1);
            end
            return;
        end
        tok_line = cur_line;
        tok_col  = cur_col;
        if (c == gnt_pkg::CH_QUOTE)
        begin
            cur_col         = count_up(cur_col);
            lit_has_content = 1'b0;
            scan_state      = SCAN_LIT;
        end
        else if (is_name_char(c))
        begin
            cur_col    = count_up(cur_col);
            kw_match   = (c == KEYWORD[0]) ? 4'd1 : gnt_pkg::KW_MISS;
            scan_state = SCAN_IDENT;
            add_result(gnt_pkg::KIND_CONTENT, c, gnt_pkg::ERR_NONE, tok_line, tok_col);
        end
        else if (c == gnt_pkg::CH_DASH)
        begin
            cur_col    = count_up(cur_col);
            scan_state = SCAN_DASH;
        end
        else if (c == gnt_pkg::CH_BAR || c == gnt_pkg::CH_AMP ||
                 c == gnt_pkg::CH_TILDE || c == gnt_pkg::CH_SEMI)
        begin
            case (c)
                gnt_pkg::CH_BAR:   k = gnt_pkg::KIND_BAR;
                gnt_pkg::CH_AMP:   k = gnt_pkg::KIND_AMP;
                gnt_pkg::CH_TILDE: k = gnt_pkg::KIND_TILDE;
                default:           k = gnt_pkg::KIND_SEMI;
            endcase
            cur_col = count_up(cur_col);
            add_result(k, 8'h00, gnt_pkg::ERR_NONE, tok_line, tok_col);
        end
        else
        begin
            raise_fault(gnt_pkg::ERR_UNKNOWN);
        end
    endfunction

    // Ordinary byte inside a literal
    function automatic void lit_char(input logic [7:0] c);
        cur_col = count_up(cur_col);
        if (c == gnt_pkg::CH_QUOTE)
        begin
            scan_state = SCAN_IDLE;
            if (!lit_has_content)
                raise_fault(gnt_pkg::ERR_EMPTY);
            else
                add_result(gnt_pkg::KIND_LITERAL, 8'h00, gnt_pkg::ERR_NONE,
                           tok_line, tok_col);
        end
        else if (c == gnt_pkg::CH_BSLASH)
        begin
            scan_state = SCAN_LIT_ESC;
        end
        else
        begin
            lit_has_content = 1'b1;
            add_result(gnt_pkg::KIND_CONTENT, c, gnt_pkg::ERR_NONE, tok_line, tok_col);
        end
    endfunction

    // Advance the shadow tokenizer by one accepted word and queue its results
    function automatic void predict_word(input logic [7:0] c, input logic endm);
        step_n = 0;
        case (scan_state)
            SCAN_IDLE:
                if (endm)
                    add_result(gnt_pkg::KIND_END, 8'h00, gnt_pkg::ERR_NONE,
                               cur_line, cur_col);
                else
                    idle_char(c);
            SCAN_IDENT:
                if (!endm && is_name_char(c))
                begin
                    cur_col = count_up(cur_col);
                    if (kw_match < gnt_pkg::KW_LEN && c == KEYWORD[kw_match])
                        kw_match = kw_match + 4'd1;
                    else
                        kw_match = gnt_pkg::KW_MISS;
                    add_result(gnt_pkg::KIND_CONTENT, c, gnt_pkg::ERR_NONE,
                               tok_line, tok_col);
                end
                else
                begin
                    if (kw_match == gnt_pkg::KW_LEN)
                        add_result(gnt_pkg::KIND_EPSILON, 8'h00, gnt_pkg::ERR_NONE,
                                   tok_line, tok_col);
                    else
                        add_result(gnt_pkg::KIND_NONTERM, 8'h00, gnt_pkg::ERR_NONE,
                                   tok_line, tok_col);
                    scan_state = SCAN_IDLE;
                    if (endm)
                        add_result(gnt_pkg::KIND_END, 8'h00, gnt_pkg::ERR_NONE,
                                   cur_line, cur_col);
                    else
                        idle_char(c);
                end
            SCAN_LIT:
                if (endm)
                    raise_fault(gnt_pkg::ERR_UNTERM);
                else
                    lit_char(c);
            SCAN_LIT_ESC:
                if (endm)
                begin
                    raise_fault(gnt_pkg::ERR_UNTERM);
                end
                else if (c == gnt_pkg::CH_QUOTE)
                begin
                    cur_col         = count_up(cur_col);
                    lit_has_content = 1'b1;
                    scan_state      = SCAN_LIT;
                    add_result(gnt_pkg::KIND_CONTENT, gnt_pkg::CH_QUOTE, gnt_pkg::ERR_NONE,
                               tok_line, tok_col);
                end
                else
                begin
                    lit_has_content = 1'b1;
                    scan_state      = SCAN_LIT;
                    add_result(gnt_pkg::KIND_CONTENT, gnt_pkg::CH_BSLASH, gnt_pkg::ERR_NONE,
                               tok_line, tok_col);
                    lit_char(c);
                end
            SCAN_DASH:
                if (!endm && c == gnt_pkg::CH_GT)
                begin
                    cur_col    = count_up(cur_col);
                    scan_state = SCAN_IDLE;
                    add_result(gnt_pkg::KIND_ARROW, 8'h00, gnt_pkg::ERR_NONE,
                               tok_line, tok_col);
                end
                else
                begin
                    raise_fault(gnt_pkg::ERR_DASH);
                end
            default:
                scan_state = SCAN_HALT;
        endcase
        if (step_n > 0)
            step_out[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_tokens.insert(expected_tokens.size(), step_out[i]);
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare taken results and predict accepted source words
    always @(posedge clk)
    begin : monitor
        gnt_pkg::res_t want;
        if (rst_n)
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: result with none expected, actual kind %0d byte %0d err %0d",
                             $time, out_if.kind, out_if.content_byte, out_if.error_code);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("kind", 32'(want.kind), 32'(out_if.kind));
                    check_field("content_byte", 32'(want.content_byte),
                                32'(out_if.content_byte));
                    check_field("error_code", 32'(want.error_code), 32'(out_if.error_code));
                    check_field("token_line", 32'(want.token_line), 32'(out_if.token_line));
                    check_field("token_column", 32'(want.token_column),
                                32'(out_if.token_column));
                    check_field("last", 32'(want.last), 32'(out_if.last));
                end
            end
            if (in_if.valid && in_if.ready)
                predict_word(in_if.in_byte, in_if.end_mark);
        end
        word_taken <= rst_n && in_if.valid && in_if.ready;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------- driving

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!sender_pace || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (!sink_pace || r < 75)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Present source words, holding each until taken
    always @(negedge clk)
    begin : source_driver
        logic present;
        present = feed_valid;
        if (rst_n)
        begin
            if (feed_valid && word_taken)
            begin
                void'(source_text.pop_front());
                present  = 1'b0;
                gap_left = pick_gap();
            end
            if (!present)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (source_text.size() > 0)
                    present = 1'b1;
            end
            feed_valid <= present;
            if (present)
            begin
                feed_byte <= source_text[0].ch;
                feed_end  <= source_text[0].endm;
            end
        end
    end

    // Drive result ready with random stalls and the requested long hold
    always @(negedge clk)
    begin : result_sink
        logic rdy;
        rdy = 1'b1;
        if (hold_requests != holds_served)
        begin
            holds_served++;
            long_hold_left = LONG_HOLD;
        end
        if (long_hold_left > 0)
        begin
            long_hold_left--;
            rdy = 1'b0;
        end
        else
        begin
            if (stall_left == 0)
                stall_left = pick_stall();
            if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
        end
        take_ready <= rdy;
    end

    // ---------------------------------------------------------------- stimulus

    task automatic put_char(input logic [7:0] b);
        src_word_t w;
        w.ch   = b;
        w.endm = 1'b0;
        source_text.insert(source_text.size(), w);
        words_queued++;
    endtask

    task automatic put_end();
        src_word_t w;
        w.ch   = 8'($urandom_range(0, 255));
        w.endm = 1'b1;
        source_text.insert(source_text.size(), w);
        words_queued++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0:       return gnt_pkg::CH_SPACE;
            1:       return 8'h09;
            2:       return gnt_pkg::CH_LF;
            3:       return 8'h0B;
            4:       return 8'h0C;
            default: return gnt_pkg::CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] name_char();
        return NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)];
    endfunction

    function automatic logic [7:0] plain_lit_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == gnt_pkg::CH_QUOTE || b == gnt_pkg::CH_BSLASH)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic put_blank();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 10) : $urandom_range(0, 2);
        repeat (n) put_char(blank_char());
    endtask

    // Identifier, often near the keyword
    task automatic put_name();
        int n;
        case ($urandom_range(0, 7))
            0, 1:
                put_text("epsilon");
            2:
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    put_char(KEYWORD[i]);
            end
            3:
            begin
                put_text("epsilon");
                put_char(name_char());
            end
            4:
                put_text("epsiLon");
            default:
            begin
                n = $urandom_range(1, 8);
                repeat (n) put_char(name_char());
            end
        endcase
    endtask

    // Non-empty, properly closed literal with escapes and arbitrary bytes
    task automatic put_literal();
        int n;
        n = $urandom_range(1, 6);
        put_char(gnt_pkg::CH_QUOTE);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    put_char(gnt_pkg::CH_BSLASH);
                    put_char(gnt_pkg::CH_QUOTE);
                end
                1:
                begin
                    put_char(gnt_pkg::CH_BSLASH);
                    put_char(plain_lit_byte());
                end
                2:
                begin
                    put_char(gnt_pkg::CH_BSLASH);
                    put_char(gnt_pkg::CH_BSLASH);
                    put_char(plain_lit_byte());
                end
                3:
                    put_char(blank_char());
                default:
                    put_char(plain_lit_byte());
            endcase
        end
        put_char(gnt_pkg::CH_QUOTE);
    endtask

    task automatic put_token();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7)
            put_name();
        else if (r < 12)
            put_literal();
        else if (r < 14)
            put_text("->");
        else if (r == 14)
            put_char(gnt_pkg::CH_BAR);
        else if (r == 15)
            put_char(gnt_pkg::CH_AMP);
        else if (r == 16)
            put_char(gnt_pkg::CH_TILDE);
        else if (r == 17)
            put_char(gnt_pkg::CH_SEMI);
        else if (r == 18)
            put_end();
        else
            put_blank();
    endtask

    task automatic put_stream(input int n);
        int stop;
        stop = words_queued + n;
        while (words_queued < stop)
        begin
            put_blank();
            put_token();
        end
    endtask

    // One malformed construct; the block halts on it
    task automatic put_fault();
        logic [7:0] b;
        if ($urandom_range(0, 1))
            put_name();
        case ($urandom_range(0, 5))
            0:
            begin
                put_char(gnt_pkg::CH_QUOTE);
                put_char(gnt_pkg::CH_QUOTE);
            end
            1:
            begin
                put_char(gnt_pkg::CH_DASH);
                b = 8'($urandom_range(0, 255));
                if (b == gnt_pkg::CH_GT)
                    b = gnt_pkg::CH_SPACE;
                put_char(b);
            end
            2:
            begin
                put_char(gnt_pkg::CH_DASH);
                put_end();
            end
            3:
            begin
                b = 8'hFF;
                if ($urandom_range(0, 1))
                begin
                    b = 8'($urandom_range(0, 255));
                    while (is_blank(b) || is_name_char(b) || b == gnt_pkg::CH_QUOTE ||
                           b == gnt_pkg::CH_DASH || b == gnt_pkg::CH_BAR ||
                           b == gnt_pkg::CH_AMP || b == gnt_pkg::CH_TILDE ||
                           b == gnt_pkg::CH_SEMI)
                        b = 8'($urandom_range(0, 255));
                end
                put_char(b);
            end
            4:
            begin
                put_char(gnt_pkg::CH_QUOTE);
                put_char(plain_lit_byte());
                put_end();
            end
            default:
            begin
                put_char(gnt_pkg::CH_QUOTE);
                put_char(gnt_pkg::CH_BSLASH);
                put_end();
            end
        endcase
        // Trailing words are dropped while halted
        repeat (20)
        begin
            if ($urandom_range(0, 3) == 0)
                put_end();
            else
                put_char(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_source_done();
        while (source_text.size() != 0 || feed_valid)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        wait_source_done();
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : sequence_main
        int goal;
        int seg;

        // Hold reset, release on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Keyword, arrow, escaped literal with extreme bytes, marks, line breaks, end
        sender_pace = 1'b1;
        sink_pace   = 1'b1;
        put_text("epsilon->");
        put_char(gnt_pkg::CH_QUOTE);
        put_char(gnt_pkg::CH_BSLASH);
        put_char(gnt_pkg::CH_QUOTE);
        put_char(gnt_pkg::CH_BSLASH);
        put_char("q");
        put_char(8'hFF);
        put_char(8'h00);
        put_char(gnt_pkg::CH_QUOTE);
        put_text("|&~;");
        put_char(gnt_pkg::CH_CR);
        put_char(gnt_pkg::CH_LF);
        put_char(8'h09);
        put_char("Z");
        put_end();
        wait_drained();

        // Random well-formed token streams in segments of varying pace
        goal = words_queued + RANDOM_WORDS;
        seg  = 0;
        while (words_queued < goal)
        begin
            if (seg % 3 == 0)
            begin
                sender_pace = 1'b0;
                sink_pace   = 1'b0;
            end
            else
            begin
                sender_pace = $urandom_range(0, 3) != 0;
                sink_pace   = $urandom_range(0, 3) != 0;
            end
            if (seg == 2)
            begin
                // Stall the result side while words keep coming
                sender_pace = 1'b0;
                hold_requests++;
            end
            put_stream($urandom_range(60, 180));
            if (seg == 2 || $urandom_range(0, 1))
                wait_drained();
            seg++;
        end
        wait_drained();

        // Finish with one malformed construct
        sender_pace = 1'b1;
        sink_pace   = 1'b1;
        put_fault();

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && expected_tokens.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
